// ===== rtl/i2a_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// i2a_pkg
// Shared types and constants for the integer to decimal text converter.
// ============================================================================
package i2a_pkg;

    localparam int VALUE_W    = 32;
    localparam int CHAR_W     = 8;
    localparam int DIGIT_W    = 4;
    localparam int NUM_DIGITS = 10;
    localparam int COUNT_W    = 4;

    // floor(x / 10) == (x * RECIP_10) >> RECIP_SHIFT for every 32-bit x
    localparam logic [VALUE_W-1:0] RECIP_10    = 32'hCCCC_CCCD;
    localparam int                 RECIP_SHIFT = 35;

    localparam logic [CHAR_W-1:0] DIGIT_BASE = 8'd48;
    localparam logic [CHAR_W-1:0] DIGIT_TOP  = 8'd57;
    localparam logic [CHAR_W-1:0] MINUS_CODE = 8'd45;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } i2a_state_t;

endpackage

// ===== rtl/int32_to_decimal_ascii.sv =====
`timescale 1ns / 1ps
// Sequence: an accept state, then one divide step per decimal digit (1..10), then
// one output item per cycle unless m_tready holds it back: sign (if negative) and
// digits, MSB first. A new value is accepted only after the last char of the old
// one is registered, as the single shared divide-by-ten unit and the emit loop serve one.
// Reset (rst_n low, asynchronous) returns the sequencer to idle and drops m_tvalid.
// ============================================================================
// int32_to_decimal_ascii
// Converts a signed 32-bit integer to its decimal ASCII text, one char per item.
// ============================================================================
module int32_to_decimal_ascii
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] char_code
    output logic        m_tlast
);

    i2a_pkg::i2a_state_t state_reg, state_next;

    logic [i2a_pkg::VALUE_W-1:0] mag_reg, mag_next;
    logic [i2a_pkg::COUNT_W-1:0] nd_reg, nd_next;
    logic                        sign_reg, sign_next;
    logic [i2a_pkg::DIGIT_W-1:0] digits_reg [i2a_pkg::NUM_DIGITS];
    logic [i2a_pkg::DIGIT_W-1:0] digits_next [i2a_pkg::NUM_DIGITS];
    logic                        out_valid_reg, out_valid_next;
    logic [i2a_pkg::CHAR_W-1:0]  out_char_reg, out_char_next;
    logic                        out_last_reg, out_last_next;

    logic [i2a_pkg::VALUE_W-1:0] quot;
    logic [i2a_pkg::DIGIT_W-1:0] digit;
    logic [i2a_pkg::COUNT_W-1:0] rd_idx;
    logic                        out_free;

    i2a_div10 u_div10
    (
        .mag   (mag_reg),
        .quot  (quot),
        .digit (digit)
    );

    assign s_tready = (state_reg == i2a_pkg::ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tlast  = out_last_reg;

    assign rd_idx   = nd_reg - i2a_pkg::COUNT_W'(1);
    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        nd_next        = nd_reg;
        sign_next      = sign_reg;
        digits_next    = digits_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            i2a_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    sign_next  = s_tdata[31];
                    mag_next   = s_tdata[31] ? (32'd0 - s_tdata) : s_tdata;
                    nd_next    = '0;
                    state_next = i2a_pkg::ST_CONV;
                end
            end
            i2a_pkg::ST_CONV:
            begin
                // store each digit at its place, least significant at the bottom
                digits_next[nd_reg] = digit;
                mag_next = quot;
                nd_next  = nd_reg + i2a_pkg::COUNT_W'(1);
                if (quot == '0)
                begin
                    state_next = i2a_pkg::ST_EMIT;
                end
            end
            i2a_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (sign_reg)
                    begin
                        out_char_next = i2a_pkg::MINUS_CODE;
                        out_last_next = 1'b0;
                        sign_next     = 1'b0;
                    end
                    else
                    begin
                        out_char_next = i2a_pkg::DIGIT_BASE +
                                        {4'b0000, digits_reg[rd_idx]};
                        out_last_next = (nd_reg == i2a_pkg::COUNT_W'(1));
                        nd_next       = rd_idx;
                        if (nd_reg == i2a_pkg::COUNT_W'(1))
                        begin
                            state_next = i2a_pkg::ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = i2a_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= i2a_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            nd_reg        <= '0;
            sign_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            nd_reg        <= nd_next;
            sign_reg      <= sign_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg      <= mag_next;
        digits_reg   <= digits_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

`ifndef SYNTHESIS
    // a sign is never the final char
    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata == i2a_pkg::MINUS_CODE)) |-> !m_tlast)
        else $error("minus sign flagged as last char");

    // every char is a minus or a decimal digit
    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata == i2a_pkg::MINUS_CODE) ||
                      ((m_tdata >= i2a_pkg::DIGIT_BASE) &&
                       (m_tdata <= i2a_pkg::DIGIT_TOP))))
        else $error("output char out of range");

    // digit count never exceeds ten during division
    a_digit_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == i2a_pkg::ST_CONV) |->
            (nd_reg < i2a_pkg::COUNT_W'(i2a_pkg::NUM_DIGITS)))
        else $error("digit count overflow");

    // after an accept the input is blocked and the digit count starts at zero
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (!s_tready && (nd_reg == '0)))
        else $error("input not blocked after accept");
`endif

endmodule

// ===== rtl/i2a_div10.sv =====
`timescale 1ns / 1ps
// ============================================================================
// i2a_div10
// Divide-by-ten step: quotient by reciprocal multiply, remainder as a digit.
// ============================================================================
module i2a_div10
(
    input  logic [i2a_pkg::VALUE_W-1:0] mag,
    output logic [i2a_pkg::VALUE_W-1:0] quot,
    output logic [i2a_pkg::DIGIT_W-1:0] digit
);

    logic [2*i2a_pkg::VALUE_W-1:0] prod;
    logic [i2a_pkg::DIGIT_W-1:0]   q_lo;
    logic [i2a_pkg::DIGIT_W-1:0]   q_times_10;

    assign prod = {{i2a_pkg::VALUE_W{1'b0}}, mag} *
                  {{i2a_pkg::VALUE_W{1'b0}}, i2a_pkg::RECIP_10};
    assign quot = i2a_pkg::VALUE_W'(prod >> i2a_pkg::RECIP_SHIFT);

    // remainder is below ten, so the low four bits of mag - 10*q are enough
    assign q_lo       = quot[i2a_pkg::DIGIT_W-1:0];
    assign q_times_10 = i2a_pkg::DIGIT_W'({q_lo, 3'b000} + {q_lo, 1'b0});
    assign digit      = mag[i2a_pkg::DIGIT_W-1:0] - q_times_10;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for the signed 32-bit integer to decimal text converter.
// A short table of values runs first: zero, the extremes, decade boundaries
// and the most negative value. Fixed text is given where it is obvious, and
// the rest is predicted. Random values follow, with a mix of full-range words
// and magnitudes of every digit count. Both stream sides idle at random.
// Each output character and its last flag are compared with the oldest
// predicted character.
// ============================================================================
module tb;

    localparam int RANDOM_ITEMS  = 460;
    localparam int DRAIN_CYCLES  = 30;
    localparam int STALL_LIMIT   = 2000;
    localparam int DIRECTED_ROWS = 22;

    typedef struct packed
    {
        logic [i2a_pkg::CHAR_W-1:0] code;
        logic                       last;
    } text_char_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    text_char_t  pending_chars [$];
    int          err_count = 0;
    int          quiet_cycles = 0;
    int unsigned rx_stall = 0;
    bit          no_idle = 1'b0;

    logic [31:0] table_value [DIRECTED_ROWS] = '{
        32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd10,
        32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd99, 32'd100,
        32'd999_999_999, 32'd1_000_000_000, -32'sd999_999_999,
        -32'sd1_000_000_000, 32'h5555_5555, 32'hAAAA_AAAA, 32'd7,
        32'd123_456_789, -32'sd987_654_321, 32'd65536, -32'sd5
    };
    string table_text [DIRECTED_ROWS] = '{
        "0", "1", "-1", "9", "10", "-10",
        "2147483647", "-2147483648", "-2147483647", "", "",
        "999999999", "1000000000", "-999999999",
        "-1000000000", "", "", "7",
        "", "", "", "-5"
    };

    int32_to_decimal_ascii DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [31:0] value
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // [7:0] char_code
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    // Queue the decimal text of one value, sign first, most significant digit first.
    function automatic void predict_text(input logic [31:0] v);
        logic [31:0] mag;
        logic [3:0]  digit_buf [i2a_pkg::NUM_DIGITS];
        int          nd;
        text_char_t  ch;
        mag = v[31] ? (~v + 32'd1) : v;
        nd = 0;
        do
        begin
            digit_buf[nd] = 4'(mag % 32'd10);
            mag = mag / 32'd10;
            nd++;
        end
        while (mag != 0 && nd < i2a_pkg::NUM_DIGITS);
        if (v[31])
        begin
            ch.code = i2a_pkg::MINUS_CODE;
            ch.last = 1'b0;
            pending_chars.push_back(ch);
        end
        for (int i = nd - 1; i >= 0; i--)
        begin
            ch.code = i2a_pkg::DIGIT_BASE + i2a_pkg::CHAR_W'(digit_buf[i]);
            ch.last = (i == 0);
            pending_chars.push_back(ch);
        end
    endfunction

    function automatic void queue_fixed_text(input string t);
        text_char_t ch;
        for (int i = 0; i < t.len(); i++)
        begin
            ch.code = t[i];
            ch.last = (i == t.len() - 1);
            pending_chars.push_back(ch);
        end
    endfunction

    // Mostly short gaps, a few long ones; none while a burst stretch is on.
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (no_idle)
            return 0;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    // Value with a chosen decimal digit count and a random sign.
    function automatic logic [31:0] pick_sized_value();
        int unsigned ndig;
        int unsigned lo;
        int unsigned hi;
        int unsigned mag;
        bit          neg;
        ndig = $urandom_range(10, 1);
        neg  = $urandom_range(1);
        lo   = 1;
        for (int i = 1; i < ndig; i++)
            lo = lo * 10;
        if (ndig == 1)
            lo = 0;
        hi = (ndig == 10) ? (32'h7FFF_FFFF + 32'(neg)) : (lo == 0 ? 9 : lo * 10 - 1);
        if ($urandom_range(7) == 0)
            mag = $urandom_range(1) ? lo : hi;
        else
            mag = $urandom_range(hi, lo);
        return neg ? (~mag + 32'd1) : mag;
    endfunction

    task automatic send_value(input logic [31:0] v, input string fixed_text);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (fixed_text.len() != 0)
            queue_fixed_text(fixed_text);
        else
            predict_text(v);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_value(table_value[i], table_text[i]);
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 40 == 0)
                no_idle = ($urandom_range(3) == 0);
            case ($urandom_range(9))
                0, 1, 2, 3: send_value($urandom, "");
                default:    send_value(pick_sized_value(), "");
            endcase
        end
        s_tvalid <= 1'b0;
        while (pending_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Output side back-pressure.
    always @(posedge clk)
    begin
        if (rx_stall != 0)
        begin
            m_tready <= 1'b0;
            rx_stall <= rx_stall - 1;
        end
        else
        begin
            int unsigned gap;
            gap = pick_gap();
            m_tready <= (gap == 0);
            if (gap != 0)
                rx_stall <= gap - 1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_chars.size() == 0)
                report_mismatch($sformatf("unexpected char 0x%02h last %0b", m_tdata, m_tlast));
            else
            begin
                text_char_t want;
                want = pending_chars.pop_front();
                if (m_tdata !== want.code)
                    report_mismatch($sformatf("char 0x%02h, want 0x%02h", m_tdata, want.code));
                if (m_tlast !== want.last)
                    report_mismatch($sformatf("last %0b, want %0b on char 0x%02h",
                                              m_tlast, want.last, want.code));
            end
        end
    end

    // Stop a hung run: count cycles with no item moving on either side.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

endmodule
